[rtl/afs_pkg.sv]
// Shared constants, codes and types of the array set-operation filter.
package afs_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int DATA_W       = 32;
   localparam int INDEX_W      = 5;
   localparam int OP_W         = 2;
   localparam int MODE_W       = 3;
   localparam int SIZE_W       = 6;
   localparam int ADDR_W       = 3;
   localparam int PDATA_W      = 32;

   localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN     = 2'd2;

   localparam logic [MODE_W-1:0] MODE_CONCAT     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COMMON     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_A_MINUS_B  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_B_MINUS_A  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SYM_DIFF   = 3'd4;

   localparam logic REG_MODE     = 1'b0;
   localparam logic REG_SET_SIZE = 1'b1;

   localparam logic [MODE_W-1:0] MODE_RESET     = MODE_CONCAT;
   localparam logic [SIZE_W-1:0] SET_SIZE_RESET = 6'd20;

   // read addresses of both element stores
   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
   } rd_addr_type;

   // run command to the sequencer
   typedef struct packed {
      logic              start;
      logic [MODE_W-1:0] mode;
      logic [CNT_W-1:0]  count;
   } run_cmd_type;

endpackage

[rtl/afs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module afs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/afs_run.sv]
// Run sequencer: walks the stores, tests membership, holds back one result for the last flag.
module afs_run (
   input  logic                      clock,
   input  logic                      reset,
   input  afs_pkg::run_cmd_type      cmd,
   output logic                      busy,
   output afs_pkg::rd_addr_type      rd_addr,
   input  logic [afs_pkg::DATA_W-1:0] a_rdata,
   input  logic [afs_pkg::DATA_W-1:0] b_rdata,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [afs_pkg::DATA_W-1:0] rsp_element,
   output logic                      rsp_empty_res,
   output logic                      rsp_last
);
   import afs_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [IDX_W-1:0]  nm1_ff, nm1_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic              side_ff, side_in;
   logic              found_ff, found_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [DATA_W-1:0] pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              eq;
   logic              hit;
   logic              want;
   logic              last_inner;
   logic              last_outer;
   logic              advance;
   logic [DATA_W-1:0] cur_val;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign eq         = (a_rdata == b_rdata);
   assign hit        = found_ff | eq;
   assign cur_val    = side_ff ? b_rdata : a_rdata;
   assign last_inner = (mode_ff == MODE_CONCAT) || (j_ff == nm1_ff);
   assign last_outer = (i_ff == nm1_ff);
   assign rd_addr.a  = side_ff ? j_ff : i_ff;
   assign rd_addr.b  = side_ff ? i_ff : j_ff;

   always_comb begin
      case (mode_ff)
         MODE_CONCAT: want = 1'b1;
         MODE_COMMON: want = hit;
         default:     want = !hit;
      endcase
   end

   assign advance = (state_ff == ST_DECIDE) && (!want || !pend_valid_ff || out_free);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      nm1_in         = nm1_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      side_in        = side_ff;
      found_in       = found_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_element_in = rsp_element_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_last_in    = rsp_last_ff;
      rd_valid_in    = (state_ff == ST_ISSUE);

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               mode_in  = cmd.mode;
               nm1_in   = IDX_W'(cmd.count - CNT_W'(1));
               i_in     = '0;
               j_in     = '0;
               found_in = 1'b0;
               side_in  = (cmd.mode == MODE_B_MINUS_A);
               if (cmd.count == '0 || cmd.mode > MODE_SYM_DIFF) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (rd_valid_ff) begin
               found_in = found_ff | eq;
            end
            if (last_inner) begin
               state_in = ST_DECIDE;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DECIDE: begin
            if (advance) begin
               if (want) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_element_in = pend_ff;
                     rsp_empty_in   = 1'b0;
                     rsp_last_in    = 1'b0;
                  end
                  pend_in       = cur_val;
                  pend_valid_in = 1'b1;
               end
               found_in = 1'b0;
               j_in     = '0;
               state_in = ST_ISSUE;
               case (mode_ff)
                  MODE_CONCAT: begin
                     if (last_outer) begin
                        if (!side_ff) begin
                           side_in = 1'b1;
                           i_in    = '0;
                        end else begin
                           state_in = ST_FINISH;
                        end
                     end else begin
                        i_in = i_ff + IDX_W'(1);
                     end
                  end
                  MODE_SYM_DIFF: begin
                     if (!side_ff) begin
                        side_in = 1'b1;
                     end else if (last_outer) begin
                        state_in = ST_FINISH;
                     end else begin
                        side_in = 1'b0;
                        i_in    = i_ff + IDX_W'(1);
                     end
                  end
                  default: begin
                     if (last_outer) begin
                        state_in = ST_FINISH;
                     end else begin
                        i_in = i_ff + IDX_W'(1);
                     end
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_element_in = pend_valid_ff ? pend_ff : '0;
               rsp_empty_in   = !pend_valid_ff;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         found_ff      <= 1'b0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         found_ff      <= found_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      nm1_ff         <= nm1_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      side_ff        <= side_in;
      pend_ff        <= pend_in;
      rsp_element_ff <= rsp_element_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_element   = rsp_element_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // an empty answer is a single zero transfer that closes the run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && rsp_element_ff == '0))
      else $error("empty result not flagged last or not zero");

   // read addresses must hold while a decision waits on the output
   a_decide_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !advance) |=> ($stable(rd_addr.a) && $stable(rd_addr.b)))
      else $error("read address moved during a stalled decision");

   // closing transfer returns the sequencer to idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("run did not close with a last transfer");

   // a held-back result never coexists with an idle sequencer
   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind after run");
`endif

endmodule

[rtl/array_set_operation_filter.sv]
// A load gives no transfer; loads run back to back.
// A run covers n = min(set_size, 32) elements of each store, and any output stall
// lengthens it; req_stall stays high for the whole run.
// Run time is set by the single read port of each element RAM: one compare per cycle while the output does not stall.
// Reset (synchronous, active high) clears control and sets mode 0, set_size 20; RAMs keep data.
module array_set_operation_filter (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [afs_pkg::OP_W-1:0]    req_op,
   input  logic [afs_pkg::INDEX_W-1:0] req_index,
   input  logic signed [afs_pkg::DATA_W-1:0] req_value,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [afs_pkg::DATA_W-1:0] rsp_element,
   output logic                        rsp_empty_res,
   output logic                        rsp_last,
   // APB configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [afs_pkg::ADDR_W-1:0]  paddr,
   input  logic [afs_pkg::PDATA_W-1:0] pwdata,
   output logic [afs_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);
   import afs_pkg::*;

   // configuration registers
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [SIZE_W-1:0] set_size_ff, set_size_in;
   logic              reg_sel;
   logic              cfg_wr;

   // input side
   logic              req_xfer;
   logic              idx_ok;
   logic              wr_a;
   logic              wr_b;
   logic              busy;
   run_cmd_type       cmd;
   rd_addr_type       rd_addr;
   logic [DATA_W-1:0] a_rdata;
   logic [DATA_W-1:0] b_rdata;
   logic [DATA_W-1:0] element;

   // ---------------- configuration ----------------
   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_comb begin
      mode_in     = mode_ff;
      set_size_in = set_size_ff;
      if (cfg_wr) begin
         case (reg_sel)
            REG_MODE:     mode_in     = pwdata[MODE_W-1:0];
            REG_SET_SIZE: set_size_in = pwdata[SIZE_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MODE:     prdata = PDATA_W'(mode_ff);
         REG_SET_SIZE: prdata = PDATA_W'(set_size_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RESET;
         set_size_ff <= SET_SIZE_RESET;
      end else begin
         mode_ff     <= mode_in;
         set_size_ff <= set_size_in;
      end
   end

   // ---------------- input transfers ----------------
   // Stall for the whole run; loads and unused ops are taken every cycle otherwise.
   assign req_stall = busy;
   assign req_xfer  = req_valid && !req_stall;
   assign idx_ok    = (32'(req_index) < 32'(MAX_ELEMENTS));
   assign wr_a      = req_xfer && (req_op == OP_WRITE_A) && idx_ok;
   assign wr_b      = req_xfer && (req_op == OP_WRITE_B) && idx_ok;

   // run command; element count saturates at the store depth
   assign cmd.start = req_xfer && (req_op == OP_RUN);
   assign cmd.mode  = mode_ff;
   assign cmd.count = (set_size_ff > SIZE_W'(MAX_ELEMENTS)) ?
                      CNT_W'(MAX_ELEMENTS) : CNT_W'(set_size_ff);

   // ---------------- element stores ----------------
   afs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (req_index[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr.a),
      .rd_data (a_rdata)
   );

   afs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (req_index[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr.b),
      .rd_data (b_rdata)
   );

   // ---------------- run sequencer ----------------
   // Each outer element is re-read alongside the inner sweep, so no hold register
   // is needed; one result is held back until the next one (or the end) is known.
   afs_run u_run (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .busy          (busy),
      .rd_addr       (rd_addr),
      .a_rdata       (a_rdata),
      .b_rdata       (b_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_element   (element),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

   assign rsp_element = element;

endmodule
